### rtl/sch_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sch_pkg;

    localparam int REG_W  = 12;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 4;
    localparam int IDX_W  = ADDR_W - 2;
    localparam int RSQ_W  = 2 * REG_W;

    localparam logic [IDX_W-1:0] REG_CENTER_X = 2'd0;
    localparam logic [IDX_W-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [IDX_W-1:0] REG_RADIUS   = 2'd2;

    localparam logic [REG_W-1:0] CENTER_X_RST = 12'd120;
    localparam logic [REG_W-1:0] CENTER_Y_RST = 12'd120;
    localparam logic [REG_W-1:0] RADIUS_RST   = 12'd110;
    localparam logic [RSQ_W-1:0] RSQ_RST      = 24'd12100;

    typedef struct packed {
        logic load_a;
        logic load_b;
    } mul_en_t;

endpackage

`default_nettype wire

### rtl/sch_wmul.sv
`timescale 1ns / 1ps
`default_nettype none

module sch_wmul
    import sch_pkg::*;
#(
    parameter int W = 35
)
(
    input  wire logic           clk,
    input  wire mul_en_t        en,
    input  wire logic [W-1:0]   x,
    input  wire logic [W-1:0]   y,
    output logic      [2*W-1:0] p
);

    localparam int LW = (W + 1) / 2;
    localparam int HW = W - LW;
    localparam int LL = 2 * LW;
    localparam int LH = LW + HW;
    localparam int HH = 2 * HW;
    localparam int PW = 2 * W;

    logic [LL-1:0] pp_ll_reg;
    logic [LH-1:0] pp_lh_reg;
    logic [LH-1:0] pp_hl_reg;
    logic [HH-1:0] pp_hh_reg;
    logic [PW-1:0] prod_reg;

    logic [LL-1:0] pp_ll_next;
    logic [LH-1:0] pp_lh_next;
    logic [LH-1:0] pp_hl_next;
    logic [HH-1:0] pp_hh_next;
    logic [PW-1:0] prod_next;

    always_comb
    begin
        pp_ll_next = LL'(x[LW-1:0]) * LL'(y[LW-1:0]);
        pp_lh_next = LH'(x[LW-1:0]) * LH'(y[W-1:LW]);
        pp_hl_next = LH'(x[W-1:LW]) * LH'(y[LW-1:0]);
        pp_hh_next = HH'(x[W-1:LW]) * HH'(y[W-1:LW]);
    end

    always_comb
    begin
        prod_next = PW'(pp_ll_reg)
                  + (PW'(pp_lh_reg) << LW)
                  + (PW'(pp_hl_reg) << LW)
                  + (PW'(pp_hh_reg) << LL);
    end

    always_ff @(posedge clk)
    begin
        if (en.load_a)
        begin
            pp_ll_reg <= pp_ll_next;
            pp_lh_reg <= pp_lh_next;
            pp_hl_reg <= pp_hl_next;
            pp_hh_reg <= pp_hh_next;
        end
        if (en.load_b)
        begin
            prod_reg <= prod_next;
        end
    end

    assign p = prod_reg;

endmodule

`default_nettype wire

### rtl/segment_circle_hit_test_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Segment versus circle hit test.
// Input channel (in_valid/in_ready): one request per segment, endpoints start_x/start_y
// and end_x/end_y as signed COORD_BITS-wide pixel coordinates.
// Output channel (out_valid/out_ready): one hit bit per request, in request order.
// Circle center and radius are set over the APB port (center_x at 0x0, center_y at
// 0x4, radius at 0x8); write them only while no request is in flight.
// Pipeline: eight register stages; a request accepted into stage 1 shows its result
// on out_valid when it reaches stage 8, and stays there while the output is stalled.
// Throughput: one request per cycle while out_ready is high; the wide products use split
// partial-product multipliers with 16-bit low and 15-bit high halves (default COORD_BITS).
// Reset: registers return to center (120,120), radius 110; the pipeline empties.
// Stall: while out_ready is low each stage holds its request, bubbles in front
// close up, and in_ready falls once every stage holds a request.

module segment_circle_hit_test_core
    import sch_pkg::*;
#(
    parameter int COORD_BITS = 14
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic        [ADDR_W-1:0]     paddr,
    input  wire logic        [DATA_W-1:0]     pwdata,
    output logic             [DATA_W-1:0]     prdata,
    output logic                              pready,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [COORD_BITS-1:0] start_x,
    input  wire logic signed [COORD_BITS-1:0] start_y,
    input  wire logic signed [COORD_BITS-1:0] end_x,
    input  wire logic signed [COORD_BITS-1:0] end_y,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              hit
);

    localparam int CW   = COORD_BITS;
    localparam int DW   = ((CW > 13) ? CW : 13) + 1;
    localparam int PDW  = 2 * DW;
    localparam int SW   = 2 * DW - 2;
    localparam int XW   = 2 * DW - 1;
    localparam int PFW  = 2 * DW - 1;
    localparam int BW   = 2 * DW + 1;
    localparam int MSW  = 2 * DW + 2;
    localparam int MW   = 2 * DW + 1;
    localparam int PW   = 2 * MW;
    localparam int QW   = PW + 1;
    localparam int NSTG = 8;

    // configuration
    logic [REG_W-1:0] center_x_reg, center_x_next;
    logic [REG_W-1:0] center_y_reg, center_y_next;
    logic [REG_W-1:0] radius_reg, radius_next;
    logic [RSQ_W-1:0] rsq_reg, rsq_next;
    logic             cfg_wr;
    logic [IDX_W-1:0] cfg_idx;

    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;

    always_comb
    begin
        center_x_next = center_x_reg;
        center_y_next = center_y_reg;
        radius_next   = radius_reg;
        if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_CENTER_X: center_x_next = pwdata[REG_W-1:0];
                REG_CENTER_Y: center_y_next = pwdata[REG_W-1:0];
                REG_RADIUS:   radius_next   = pwdata[REG_W-1:0];
                default:      ;
            endcase
        end
        rsq_next = RSQ_W'(radius_reg) * RSQ_W'(radius_reg);
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_CENTER_X: prdata = DATA_W'(center_x_reg);
            REG_CENTER_Y: prdata = DATA_W'(center_y_reg);
            REG_RADIUS:   prdata = DATA_W'(radius_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= CENTER_X_RST;
            center_y_reg <= CENTER_Y_RST;
            radius_reg   <= RADIUS_RST;
            rsq_reg      <= RSQ_RST;
        end
        else
        begin
            center_x_reg <= center_x_next;
            center_y_reg <= center_y_next;
            radius_reg   <= radius_next;
            rsq_reg      <= rsq_next;
        end
    end

    // pipeline control
    logic [NSTG:1]   vld_reg, vld_next;
    logic [NSTG+1:1] adv;

    always_comb
    begin
        adv[NSTG+1] = out_ready;
        for (int k = NSTG; k >= 1; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next = (adv[NSTG:1] & {vld_reg[NSTG-1:1], in_valid})
                 | (~adv[NSTG:1] & vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = adv[1];
    assign out_valid = vld_reg[NSTG];

    // stage 1: offsets from center and segment direction
    logic signed [DW-1:0] cx_ext, cy_ext;
    logic signed [DW-1:0] s1_fx_next, s1_fy_next, s1_gx_next, s1_gy_next;
    logic signed [DW-1:0] s1_dx_next, s1_dy_next;
    logic signed [DW-1:0] s1_fx_reg, s1_fy_reg, s1_gx_reg, s1_gy_reg;
    logic signed [DW-1:0] s1_dx_reg, s1_dy_reg;

    always_comb
    begin
        cx_ext     = DW'($signed({1'b0, center_x_reg}));
        cy_ext     = DW'($signed({1'b0, center_y_reg}));
        s1_fx_next = DW'(start_x) - cx_ext;
        s1_fy_next = DW'(start_y) - cy_ext;
        s1_gx_next = DW'(end_x) - cx_ext;
        s1_gy_next = DW'(end_y) - cy_ext;
        s1_dx_next = DW'(end_x) - DW'(start_x);
        s1_dy_next = DW'(end_y) - DW'(start_y);
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_fx_reg <= s1_fx_next;
            s1_fy_reg <= s1_fy_next;
            s1_gx_reg <= s1_gx_next;
            s1_gy_reg <= s1_gy_next;
            s1_dx_reg <= s1_dx_next;
            s1_dy_reg <= s1_dy_next;
        end
    end

    // stage 2: squares and dot-product terms
    logic signed [PDW-1:0] p_fxx, p_fyy, p_gxx, p_gyy, p_dxx, p_dyy, p_fxdx, p_fydy;
    logic        [SW-1:0]  s2_fxx_reg, s2_fyy_reg, s2_gxx_reg, s2_gyy_reg;
    logic        [SW-1:0]  s2_dxx_reg, s2_dyy_reg;
    logic signed [XW-1:0]  s2_fxdx_reg, s2_fydy_reg;

    always_comb
    begin
        p_fxx  = s1_fx_reg * s1_fx_reg;
        p_fyy  = s1_fy_reg * s1_fy_reg;
        p_gxx  = s1_gx_reg * s1_gx_reg;
        p_gyy  = s1_gy_reg * s1_gy_reg;
        p_dxx  = s1_dx_reg * s1_dx_reg;
        p_dyy  = s1_dy_reg * s1_dy_reg;
        p_fxdx = s1_fx_reg * s1_dx_reg;
        p_fydy = s1_fy_reg * s1_dy_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s2_fxx_reg  <= p_fxx[SW-1:0];
            s2_fyy_reg  <= p_fyy[SW-1:0];
            s2_gxx_reg  <= p_gxx[SW-1:0];
            s2_gyy_reg  <= p_gyy[SW-1:0];
            s2_dxx_reg  <= p_dxx[SW-1:0];
            s2_dyy_reg  <= p_dyy[SW-1:0];
            s2_fxdx_reg <= p_fxdx[XW-1:0];
            s2_fydy_reg <= p_fydy[XW-1:0];
        end
    end

    // stage 3: quadratic coefficients and endpoint test
    logic        [PFW-1:0] pf_sum, pg_sum, rsq_ext;
    logic signed [PDW-1:0] dot_sum;
    logic                  s3_inside_next, s3_inside_reg;
    logic        [PFW-1:0] s3_a_next, s3_a_reg;
    logic        [PFW-1:0] s3_c_next, s3_c_reg;
    logic signed [BW-1:0]  s3_b_next, s3_b_reg;

    always_comb
    begin
        rsq_ext        = PFW'(rsq_reg);
        pf_sum         = PFW'(s2_fxx_reg) + PFW'(s2_fyy_reg);
        pg_sum         = PFW'(s2_gxx_reg) + PFW'(s2_gyy_reg);
        dot_sum        = PDW'(s2_fxdx_reg) + PDW'(s2_fydy_reg);
        s3_inside_next = (pf_sum <= rsq_ext) || (pg_sum <= rsq_ext);
        s3_a_next      = PFW'(s2_dxx_reg) + PFW'(s2_dyy_reg);
        s3_c_next      = pf_sum - rsq_ext;
        s3_b_next      = $signed({dot_sum, 1'b0});
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s3_inside_reg <= s3_inside_next;
            s3_a_reg      <= s3_a_next;
            s3_c_reg      <= s3_c_next;
            s3_b_reg      <= s3_b_next;
        end
    end

    // stage 4: root bound m = b + 2a, magnitudes for the wide squares
    logic signed [MSW-1:0] m_val;
    logic                  s4_inside_reg, s4_a_zero_reg, s4_b_pos_reg, s4_m_neg_reg;
    logic        [MW-1:0]  s4_abs_b_reg, s4_abs_m_reg, s4_a_reg, s4_c_reg;
    logic        [MW-1:0]  s4_abs_b_next, s4_abs_m_next;

    always_comb
    begin
        m_val         = MSW'(s3_b_reg) + $signed({2'b00, s3_a_reg, 1'b0});
        s4_abs_b_next = s3_b_reg[BW-1] ? MW'(-s3_b_reg) : MW'(s3_b_reg);
        s4_abs_m_next = m_val[MSW-1] ? MW'(-m_val) : MW'(m_val);
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s4_inside_reg <= s3_inside_reg;
            s4_a_zero_reg <= (s3_a_reg == '0);
            s4_b_pos_reg  <= !s3_b_reg[BW-1] && (s3_b_reg != '0);
            s4_m_neg_reg  <= m_val[MSW-1];
            s4_abs_b_reg  <= s4_abs_b_next;
            s4_abs_m_reg  <= s4_abs_m_next;
            s4_a_reg      <= MW'(s3_a_reg);
            s4_c_reg      <= MW'(s3_c_reg);
        end
    end

    // stages 5 and 6: wide multipliers
    mul_en_t       mul_en;
    logic [PW-1:0] bsq, msq, ac;

    assign mul_en.load_a = adv[5];
    assign mul_en.load_b = adv[6];

    sch_wmul #(.W(MW)) u_mul_bsq
    (
        .clk (clk),
        .en  (mul_en),
        .x   (s4_abs_b_reg),
        .y   (s4_abs_b_reg),
        .p   (bsq)
    );

    sch_wmul #(.W(MW)) u_mul_msq
    (
        .clk (clk),
        .en  (mul_en),
        .x   (s4_abs_m_reg),
        .y   (s4_abs_m_reg),
        .p   (msq)
    );

    sch_wmul #(.W(MW)) u_mul_ac
    (
        .clk (clk),
        .en  (mul_en),
        .x   (s4_a_reg),
        .y   (s4_c_reg),
        .p   (ac)
    );

    logic          s5_inside_reg, s5_a_zero_reg, s5_b_pos_reg, s5_m_neg_reg;
    logic [MW-1:0] s5_abs_b_reg, s5_abs_m_reg;
    logic          s6_inside_reg, s6_a_zero_reg, s6_b_pos_reg, s6_m_neg_reg;
    logic [MW-1:0] s6_abs_b_reg, s6_abs_m_reg;

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s5_inside_reg <= s4_inside_reg;
            s5_a_zero_reg <= s4_a_zero_reg;
            s5_b_pos_reg  <= s4_b_pos_reg;
            s5_m_neg_reg  <= s4_m_neg_reg;
            s5_abs_b_reg  <= s4_abs_b_reg;
            s5_abs_m_reg  <= s4_abs_m_reg;
        end
        if (adv[6])
        begin
            s6_inside_reg <= s5_inside_reg;
            s6_a_zero_reg <= s5_a_zero_reg;
            s6_b_pos_reg  <= s5_b_pos_reg;
            s6_m_neg_reg  <= s5_m_neg_reg;
            s6_abs_b_reg  <= s5_abs_b_reg;
            s6_abs_m_reg  <= s5_abs_m_reg;
        end
    end

    // stage 7: discriminant and square thresholds
    logic [QW:0]   disc_full;
    logic [QW-1:0] s7_lo0_next, s7_hi1_next;
    logic          s7_inside_reg, s7_a_zero_reg, s7_b_pos_reg, s7_m_neg_reg, s7_d_neg_reg;
    logic [QW-1:0] s7_d_reg, s7_bsq_reg, s7_msq_reg, s7_lo0_reg, s7_hi1_reg;

    always_comb
    begin
        disc_full   = (QW + 1)'(bsq) - ((QW + 1)'(ac) << 2);
        s7_lo0_next = QW'(bsq) + (QW'(s6_abs_b_reg) << 1) + QW'(1);
        s7_hi1_next = QW'(msq) + (QW'(s6_abs_m_reg) << 1) + QW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            s7_inside_reg <= s6_inside_reg;
            s7_a_zero_reg <= s6_a_zero_reg;
            s7_b_pos_reg  <= s6_b_pos_reg;
            s7_m_neg_reg  <= s6_m_neg_reg;
            s7_d_neg_reg  <= disc_full[QW];
            s7_d_reg      <= disc_full[QW-1:0];
            s7_bsq_reg    <= QW'(bsq);
            s7_msq_reg    <= QW'(msq);
            s7_lo0_reg    <= s7_lo0_next;
            s7_hi1_reg    <= s7_hi1_next;
        end
    end

    // stage 8: root interval tests against the discriminant
    logic root0_ok, root1_ok, s8_hit_next, s8_hit_reg;

    always_comb
    begin
        root0_ok    = !s7_b_pos_reg && (s7_d_reg < s7_lo0_reg)
                    && (!s7_m_neg_reg || (s7_d_reg >= s7_msq_reg));
        root1_ok    = (!s7_b_pos_reg || (s7_d_reg >= s7_bsq_reg))
                    && !s7_m_neg_reg && (s7_d_reg < s7_hi1_reg);
        s8_hit_next = s7_inside_reg
                    || (!s7_a_zero_reg && !s7_d_neg_reg && (root0_ok || root1_ok));
    end

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            s8_hit_reg <= s8_hit_next;
        end
    end

    assign hit = s8_hit_reg;

`ifndef SYNTHESIS
    ap_inside_hits: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[7] && adv[8] && s7_inside_reg) |=> hit)
        else $error("endpoint inside circle did not report hit");

    ap_degenerate_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[7] && adv[8] && !s7_inside_reg && (s7_a_zero_reg || s7_d_neg_reg))
        |=> !hit)
        else $error("point segment or negative discriminant reported hit");

    ap_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty output stage");

    ap_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(vld_reg[7]))
        else $error("result appeared without a request in the stage before");
`endif

endmodule

`default_nettype wire
